// ===== rtl/ps2d_pkg.sv =====
// Package for the PS/2 scan code decoder: byte codes, sequence sums,
// the pending-command type and the result word layout.
// No dependencies.
package ps2d_pkg;

  localparam int BYTE_W = 8;
  localparam int SUM_W  = 11;
  localparam int LOCK_W = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [LOCK_W-1:0] lock_t;

  localparam byte_t CODE_PAUSE_START = 8'hE1;
  localparam byte_t CODE_EXTEND      = 8'hE0;
  localparam byte_t CODE_RELEASE     = 8'hF0;
  localparam byte_t CODE_CTRL        = 8'h14;
  localparam byte_t CODE_BREAK_KEY   = 8'h7E;
  localparam byte_t CODE_ACK         = 8'hFA;
  localparam byte_t CODE_CAPS        = 8'h58;
  localparam byte_t CODE_SCROLL      = 8'h7E;
  localparam byte_t CODE_NUM         = 8'h77;
  localparam byte_t CMD_SET_LEDS     = 8'hED;

  localparam sum_t SUM_PAUSE       = 11'h4B8;
  localparam sum_t SUM_BREAK       = 11'h3AC;
  localparam sum_t SUM_AFTER_E1_14 = 11'd245;
  localparam sum_t SUM_SMALL_MAX   = 11'h0FF;

  // Lock bit positions in lock_bits and in the LED byte.
  localparam lock_t LOCK_SCROLL = 3'b001;
  localparam lock_t LOCK_NUM    = 3'b010;
  localparam lock_t LOCK_CAPS   = 3'b100;

  typedef enum logic [1:0] {
    SPECIAL_NONE  = 2'd0,
    SPECIAL_PAUSE = 2'd1,
    SPECIAL_BREAK = 2'd2
  } special_t;

  typedef enum logic [1:0] {
    CMD_IDLE      = 2'd0,
    CMD_WAIT_ED   = 2'd1,
    CMD_WAIT_LEDS = 2'd2
  } cmd_stage_t;

  typedef struct packed {
    logic     key_valid;
    byte_t    key_code;
    logic     key_released;
    logic     key_extended;
    special_t special_key;
    logic     send_valid;
    byte_t    send_byte;
    logic     send_parity;
    lock_t    lock_leds;
  } result_t;

endpackage

// ===== rtl/ps2d_if.sv =====
// Handshake channels of the PS/2 scan code decoder: the scan byte input
// and the decoded result output. Depends on ps2d_pkg.
interface ps2d_scan_if import ps2d_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t scan_byte;

  modport source(output valid, output scan_byte, input ready);
  modport sink(input valid, input scan_byte, output ready);
endinterface

interface ps2d_result_if import ps2d_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     key_valid;
  byte_t    key_code;
  logic     key_released;
  logic     key_extended;
  special_t special_key;
  logic     send_valid;
  byte_t    send_byte;
  logic     send_parity;
  lock_t    lock_leds;

  modport source(output valid, output key_valid, output key_code, output key_released,
                 output key_extended, output special_key, output send_valid,
                 output send_byte, output send_parity, output lock_leds, input ready);
  modport sink(input valid, input key_valid, input key_code, input key_released,
               input key_extended, input special_key, input send_valid,
               input send_byte, input send_parity, input lock_leds, output ready);
endinterface

// ===== rtl/ps2_scancode_decoder_with_lock_leds.sv =====
// PS/2 scan code set 2 decoder with lock-key LED command sequencing.
// An accepted scan word passes the input register, then the result register,
// to become its result word; one word per cycle while result words are taken.
// Input stalls only while a result word waits on a receiver that withholds ready.
// Synchronous active-high rst clears both stage valids, prefix flags, byte sum,
// pending LED command and lock bits. Depends on ps2d_pkg, ps2d_if, ps2d_core.
module ps2_scancode_decoder_with_lock_leds import ps2d_pkg::*; (
  input logic           clk,
  input logic           rst,
  ps2d_scan_if.sink     scan,
  ps2d_result_if.source result
);

  logic    in_vld;
  byte_t   in_byte;
  logic    out_vld;
  result_t out_res;
  result_t core_res;
  logic    out_free;
  logic    advance;

  assign out_free   = !out_vld || result.ready;
  assign advance    = in_vld && out_free;
  assign scan.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (scan.ready) begin
      in_vld <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      in_byte <= scan.scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_free) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  ps2d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .scan_byte (in_byte),
    .res       (core_res)
  );

  assign result.valid        = out_vld;
  assign result.key_valid    = out_res.key_valid;
  assign result.key_code     = out_res.key_code;
  assign result.key_released = out_res.key_released;
  assign result.key_extended = out_res.key_extended;
  assign result.special_key  = out_res.special_key;
  assign result.send_valid   = out_res.send_valid;
  assign result.send_byte    = out_res.send_byte;
  assign result.send_parity  = out_res.send_parity;
  assign result.lock_leds    = out_res.lock_leds;

  // A word moved out of the input register always lands in the result register.
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_vld)
    else $error("decoded word lost between stages");

  // A key event and a pause/break report never share one word.
  a_key_xor_special: assert property (@(posedge clk) disable iff (rst)
    out_vld && result.key_valid |-> result.special_key == SPECIAL_NONE)
    else $error("key event reported together with a special sequence");

  // Sent bytes carry odd parity over byte and parity bit.
  a_send_parity: assert property (@(posedge clk) disable iff (rst)
    out_vld && result.send_valid |-> (^{result.send_byte, result.send_parity}) == 1'b1)
    else $error("send parity is not odd");

  // A sent byte is either the LED command or a mask that matches the lock bits.
  a_send_byte: assert property (@(posedge clk) disable iff (rst)
    out_vld && result.send_valid |->
      result.send_byte == CMD_SET_LEDS ||
      result.send_byte == byte_t'(result.lock_leds))
    else $error("unexpected byte sent to keyboard");

  // An idle input stage accepts whatever is offered.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_vld |-> scan.ready)
    else $error("input stalled while empty");

endmodule

// ===== rtl/ps2d_core.sv =====
// Decoder state and per-byte decision logic: prefix flags, pause/break
// byte sum, LED command sequencing and lock bits. Depends on ps2d_pkg.
module ps2d_core import ps2d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  byte_t   scan_byte,
  output result_t res
);

  logic       release_seen, release_seen_next;
  logic       extend_seen, extend_seen_next;
  sum_t       sequence_sum, sequence_sum_next;
  cmd_stage_t command_stage, command_stage_next;
  lock_t      lock_bits, lock_bits_next;

  logic  capture;
  sum_t  sum_add;
  lock_t toggle;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_seen  <= 1'b0;
      extend_seen   <= 1'b0;
      sequence_sum  <= '0;
      command_stage <= CMD_IDLE;
      lock_bits     <= '0;
    end else if (step) begin
      release_seen  <= release_seen_next;
      extend_seen   <= extend_seen_next;
      sequence_sum  <= sequence_sum_next;
      command_stage <= command_stage_next;
      lock_bits     <= lock_bits_next;
    end
  end

  always_comb begin
    capture = (scan_byte == CODE_PAUSE_START) ||
              (sequence_sum == SUM_AFTER_E1_14) ||
              (sequence_sum > SUM_SMALL_MAX) ||
              (sequence_sum == sum_t'(CODE_PAUSE_START) && scan_byte == CODE_CTRL) ||
              (sequence_sum != '0 && scan_byte == CODE_BREAK_KEY);
    sum_add = sequence_sum + sum_t'(scan_byte);

    toggle = '0;
    if (scan_byte == CODE_CAPS) begin
      toggle = LOCK_CAPS;
    end else if (scan_byte == CODE_SCROLL) begin
      toggle = LOCK_SCROLL;
    end else if (scan_byte == CODE_NUM) begin
      toggle = LOCK_NUM;
    end

    release_seen_next  = release_seen;
    extend_seen_next   = extend_seen;
    sequence_sum_next  = sequence_sum;
    command_stage_next = command_stage;
    lock_bits_next     = lock_bits;
    res                = '0;
    res.special_key    = SPECIAL_NONE;

    if (capture) begin
      sequence_sum_next = sum_add;
      // Reaching either end sum, or overshooting the pause sum, closes the capture.
      if (sum_add >= SUM_PAUSE || sum_add == SUM_BREAK) begin
        if (sum_add == SUM_PAUSE) begin
          res.special_key = SPECIAL_PAUSE;
        end else if (sum_add == SUM_BREAK) begin
          res.special_key = SPECIAL_BREAK;
        end
        sequence_sum_next = '0;
        release_seen_next = 1'b0;
        extend_seen_next  = 1'b0;
      end
    end else if (scan_byte == CODE_RELEASE) begin
      release_seen_next = 1'b1;
    end else if (scan_byte == CODE_EXTEND) begin
      extend_seen_next  = 1'b1;
      sequence_sum_next = sum_t'(CODE_EXTEND);
    end else begin
      case (command_stage)
        CMD_IDLE: begin
          if (release_seen && toggle != '0) begin
            lock_bits_next     = lock_bits ^ toggle;
            res.send_valid     = 1'b1;
            res.send_byte      = CMD_SET_LEDS;
            command_stage_next = CMD_WAIT_ED;
          end
        end
        CMD_WAIT_ED: begin
          if (scan_byte == CODE_ACK) begin
            res.send_valid     = 1'b1;
            res.send_byte      = byte_t'(lock_bits);
            command_stage_next = CMD_WAIT_LEDS;
          end
        end
        default: begin
          if (scan_byte == CODE_ACK) begin
            command_stage_next = CMD_IDLE;
          end
        end
      endcase
      res.key_valid     = 1'b1;
      res.key_code      = scan_byte;
      res.key_released  = release_seen;
      res.key_extended  = extend_seen;
      release_seen_next = 1'b0;
      extend_seen_next  = 1'b0;
      sequence_sum_next = '0;
    end

    // Odd parity: the bit makes the total count of ones odd.
    res.send_parity = res.send_valid & ~(^res.send_byte);
    res.lock_leds   = lock_bits_next;
  end

endmodule
